/* rtl/core/grcast_pkg.sv */
// ----------------------------------------------------------------------------
// grcast_pkg
// Shared types, constants and tables of the grid ray wall caster.
// ----------------------------------------------------------------------------
package grcast_pkg;

  localparam int TILE_PIXELS     = 64;
  localparam int MAP_MAX_COLUMNS = 32;
  localparam int MAP_MAX_ROWS    = 32;
  localparam int CELLS           = MAP_MAX_COLUMNS * MAP_MAX_ROWS;
  localparam int CELL_AW         = $clog2(CELLS);
  localparam int COL_BITS        = $clog2(MAP_MAX_COLUMNS);
  localparam int ROW_BITS        = $clog2(MAP_MAX_ROWS);
  localparam int TQ              = $clog2(TILE_PIXELS) + 8;
  localparam int NW              = 26;
  localparam int CW              = 33;
  localparam int QW              = 47;
  localparam int SW              = 39;
  localparam int CORDIC_STEPS    = 30;

  localparam logic [SW-1:0] SLOPE_MAX = SW'(64'd1 << 38);
  localparam logic [22:0]   OFF_MAX   = 23'h40_0000;
  localparam logic [20:0]   DIST_MAX  = 21'h1F_FFFF;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH,
    CFG_SCREEN_HEIGHT,
    CFG_MAP_WIDTH,
    CFG_MAP_HEIGHT
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CORDIC, ST_DIV_INIT, ST_DIV, ST_DIV_STORE,
    ST_WALK_INIT, ST_WALK_MUL, ST_WALK_START, ST_WALK_ADDR, ST_WALK_EVAL,
    ST_SQ_INIT, ST_SQ, ST_SEL, ST_SQRT, ST_EMIT
  } state_e;

  typedef struct packed {
    logic        func;
    logic [9:0]  cell_index;
    logic        cell_is_wall;
    logic [19:0] player_x;
    logic [19:0] player_y;
    logic [11:0] heading;
    logic [9:0]  ray_number;
  } in_t;

  typedef struct packed {
    logic [9:0]  ray_number_out;
    logic        hit;
    logic [19:0] end_x;
    logic [19:0] end_y;
    logic [20:0] distance;
    logic        vert_hit;
  } out_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic cordic_step;
    logic div_init;
    logic div_step;
    logic div_store;
    logic div_sel;
    logic walk_init;
    logic walk_ax;
    logic walk_mul;
    logic walk_start;
    logic walk_addr;
    logic walk_eval;
    logic sq_init;
    logic sq_step;
    logic sel;
    logic sqrt_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_cast;
    logic cnt_last;
    logic walk_skip;
    logic walk_stop;
    logic walk_hit;
  } sts_t;

  // Arctangent of 2^-i in units of 2^-32 of a turn.
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/grcast_ctrl.sv */
// ----------------------------------------------------------------------------
// grcast_ctrl
// Sequencer of the caster: map clearing, rotation, two divisions, the two
// grid walks, distance squares, root and result beat.
// ----------------------------------------------------------------------------
module grcast_ctrl import grcast_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   div_sel_q, div_sel_d;
  logic   walk_ax_q, walk_ax_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      div_sel_q <= 1'b0;
      walk_ax_q <= 1'b1;
    end else begin
      state_q   <= state_d;
      div_sel_q <= div_sel_d;
      walk_ax_q <= walk_ax_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_sel_d = div_sel_q;
    walk_ax_d = walk_ax_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i && sts_i.is_cast) begin
          state_d   = ST_CORDIC;
          div_sel_d = 1'b0;
          walk_ax_d = 1'b1;
        end
      end
      ST_CORDIC: begin
        if (sts_i.cnt_last) state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.cnt_last) state_d = ST_DIV_STORE;
      end
      ST_DIV_STORE: begin
        if (!div_sel_q) begin
          div_sel_d = 1'b1;
          state_d   = ST_DIV_INIT;
        end else begin
          state_d = ST_WALK_INIT;
        end
      end
      ST_WALK_INIT: begin
        if (sts_i.walk_skip) begin
          if (walk_ax_q) begin
            walk_ax_d = 1'b0;
          end else begin
            state_d = ST_SQ_INIT;
          end
        end else begin
          state_d = ST_WALK_MUL;
        end
      end
      ST_WALK_MUL:   state_d = ST_WALK_START;
      ST_WALK_START: state_d = ST_WALK_ADDR;
      ST_WALK_ADDR: begin
        if (sts_i.walk_stop) begin
          if (walk_ax_q) begin
            walk_ax_d = 1'b0;
            state_d   = ST_WALK_INIT;
          end else begin
            state_d = ST_SQ_INIT;
          end
        end else begin
          state_d = ST_WALK_EVAL;
        end
      end
      ST_WALK_EVAL: begin
        if (sts_i.walk_hit) begin
          if (walk_ax_q) begin
            walk_ax_d = 1'b0;
            state_d   = ST_WALK_INIT;
          end else begin
            state_d = ST_SQ_INIT;
          end
        end else begin
          state_d = ST_WALK_ADDR;
        end
      end
      ST_SQ_INIT: state_d = ST_SQ;
      ST_SQ: begin
        if (sts_i.cnt_last) state_d = ST_SEL;
      end
      ST_SEL: state_d = ST_SQRT;
      ST_SQRT: begin
        if (sts_i.cnt_last) state_d = ST_EMIT;
      end
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = div_sel_q;
    cmd_o.walk_ax = walk_ax_q;
    busy_o        = (state_q != ST_IDLE);
    case (state_q)
      ST_CLEAR:      cmd_o.clr_step    = 1'b1;
      ST_IDLE:       cmd_o.load        = start_i;
      ST_CORDIC:     cmd_o.cordic_step = 1'b1;
      ST_DIV_INIT:   cmd_o.div_init    = 1'b1;
      ST_DIV:        cmd_o.div_step    = 1'b1;
      ST_DIV_STORE:  cmd_o.div_store   = 1'b1;
      ST_WALK_INIT:  cmd_o.walk_init   = 1'b1;
      ST_WALK_MUL:   cmd_o.walk_mul    = 1'b1;
      ST_WALK_START: cmd_o.walk_start  = 1'b1;
      ST_WALK_ADDR:  cmd_o.walk_addr   = 1'b1;
      ST_WALK_EVAL:  cmd_o.walk_eval   = 1'b1;
      ST_SQ_INIT:    cmd_o.sq_init     = 1'b1;
      ST_SQ:         cmd_o.sq_step     = 1'b1;
      ST_SEL:        cmd_o.sel         = 1'b1;
      ST_SQRT:       cmd_o.sqrt_step   = 1'b1;
      ST_EMIT:       cmd_o.emit        = 1'b1;
      default:       cmd_o             = '0;
    endcase
  end

endmodule

/* rtl/core/grcast_dp.sv */
// ----------------------------------------------------------------------------
// grcast_dp
// Datapath of the caster: configuration registers, wall map, rotation
// unit, restoring divider, grid walker, squarer and bit-serial root.
// ----------------------------------------------------------------------------
module grcast_dp import grcast_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_t         in_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        res_strobe_o,
  output out_t        res_o
);

  logic [11:0] scr_w_q, scr_h_q;
  logic [5:0]  map_w_q, map_h_q;
  logic [5:0]  mw, mh;

  logic [CELL_AW-1:0] clr_cnt_q;
  logic               mem [CELLS];
  logic               rd_q;
  logic [CELL_AW-1:0] rd_addr;

  in_t         item_q;
  logic [5:0]  cnt_q, lim_q;

  logic signed [CW-1:0] x_q, y_q, z_q, xs, ys;
  logic [30:0] c_w, s_w;

  logic [30:0]   dvs_q;
  logic [31:0]   rem_q, rem_t;
  logic [QW-1:0] quo_q;
  logic          div_ge;
  logic [SW-1:0] q1_q, q2_q, q_clamped;

  logic [9:0]  r_ang;
  logic [1:0]  quad;
  logic        odd, down, right;

  logic                 ax_q, fwd_a_q, fwd_o_q, slope_neg_q;
  logic [SW-1:0]        slope_mag_q;
  logic [TQ:0]          dmag_q;
  logic signed [NW-1:0] na_q, no_q, nx, ny, chk_a, chkx, chky;
  logic [22:0]          stepo_q;
  logic [34:0]          pp_lo_q;
  logic [33:0]          pp_hi_q;
  logic                 hok_q, vok_q;
  logic [19:0]          hpx_q [2];
  logic [19:0]          hpy_q [2];

  logic          w_ax, w_fwd_a, w_fwd_o, w_neg;
  logic [SW-1:0] w_mag;
  logic [19:0]   w_pa;
  logic [SW-3:0] w_step_raw;
  logic [53:0]   prod, prod_r;
  logic [37:0]   off_raw;
  logic [22:0]   off_c;
  logic [19:0]   po;
  logic          onscr, inmap;
  logic [19:0]   scr_xl, scr_yl, mlim_x, mlim_y;

  logic [19:0] sq_a, sq_b;
  logic [20:0] sq_diff;
  logic [19:0] sq_abs;
  logic [39:0] sq_p;
  logic [40:0] dv_q, dh_q;

  logic        use_v_q, any_q;
  logic [40:0] v_q;
  logic [41:0] res_q, sq_t;
  logic [40:0] bit_q;

  logic        res_strobe_q;
  out_t        res_oq;

  // Configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= 12'd640;
      scr_h_q <= 12'd480;
      map_w_q <= 6'd32;
      map_h_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SCREEN_WIDTH:  scr_w_q <= cfg_data_i;
        CFG_SCREEN_HEIGHT: scr_h_q <= cfg_data_i;
        CFG_MAP_WIDTH:     map_w_q <= cfg_data_i[5:0];
        CFG_MAP_HEIGHT:    map_h_q <= cfg_data_i[5:0];
        default:           scr_w_q <= scr_w_q;
      endcase
    end
  end

  assign mw = (map_w_q > 6'(MAP_MAX_COLUMNS)) ? 6'(MAP_MAX_COLUMNS) : map_w_q;
  assign mh = (map_h_q > 6'(MAP_MAX_ROWS)) ? 6'(MAP_MAX_ROWS) : map_h_q;

  // Wall map with clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_cnt_q <= '0;
    else if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem[clr_cnt_q] <= 1'b0;
    end else if (cmd_i.load && !in_i.func && ({1'b0, in_i.cell_index} < 11'(CELLS))) begin
      mem[in_i.cell_index[CELL_AW-1:0]] <= in_i.cell_is_wall;
    end
    if (cmd_i.walk_addr) rd_q <= mem[rd_addr];
  end

  // Angle decode.
  assign quad  = item_q.heading[11:10];
  assign r_ang = item_q.heading[9:0];
  assign odd   = quad[0];
  assign down  = (item_q.heading != 12'd0) && (quad[1] == 1'b0);
  assign right = (quad == 2'd0) || ((quad == 2'd3) && (r_ang != 10'd0));

  // Rotation and shared step counter.
  assign xs = x_q >>> cnt_q[4:0];
  assign ys = y_q >>> cnt_q[4:0];
  assign c_w = (x_q > 0) ? x_q[30:0] : 31'd1;
  assign s_w = (y_q > 0) ? y_q[30:0] : 31'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_i;
      x_q    <= CW'(64'd1 << 29);
      y_q    <= '0;
      z_q    <= CW'({in_i.heading[9:0], 20'd0});
    end else if (cmd_i.cordic_step) begin
      if (!z_q[CW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - $signed({3'b000, atan_turn(cnt_q[4:0])});
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + $signed({3'b000, atan_turn(cnt_q[4:0])});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cnt_q <= '0;
      lim_q <= 6'(CORDIC_STEPS - 1);
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
      lim_q <= 6'(QW - 1);
    end else if (cmd_i.sq_init) begin
      cnt_q <= '0;
      lim_q <= 6'd3;
    end else if (cmd_i.sel) begin
      cnt_q <= '0;
      lim_q <= 6'd20;
    end else if (cmd_i.cordic_step || cmd_i.div_step || cmd_i.sq_step ||
                 cmd_i.sqrt_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Restoring divider.
  assign rem_t  = {rem_q[30:0], quo_q[QW-1]};
  assign div_ge = rem_t >= {1'b0, dvs_q};
  assign q_clamped = (quo_q > QW'(SLOPE_MAX)) ? SLOPE_MAX : quo_q[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= '0;
      if (!cmd_i.div_sel) begin
        quo_q <= {s_w, 16'd0};
        dvs_q <= c_w;
      end else begin
        quo_q <= {c_w, 16'd0};
        dvs_q <= s_w;
      end
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? rem_t - {1'b0, dvs_q} : rem_t;
      quo_q <= {quo_q[QW-2:0], div_ge};
    end
    if (cmd_i.div_store) begin
      if (!cmd_i.div_sel) q1_q <= q_clamped;
      else q2_q <= q_clamped;
    end
  end

  // Grid walker.
  assign w_ax    = cmd_i.walk_ax;
  assign w_fwd_a = w_ax ? down : right;
  assign w_fwd_o = w_ax ? right : down;
  assign w_mag   = (w_ax ^ odd) ? q2_q : q1_q;
  assign w_pa    = w_ax ? item_q.player_y : item_q.player_x;
  assign w_step_raw = w_mag[SW-1:16-TQ];
  assign po      = ax_q ? item_q.player_x : item_q.player_y;

  assign prod    = {19'd0, pp_lo_q} + {pp_hi_q, 20'd0};
  assign w_neg   = slope_neg_q ^ !fwd_a_q;
  assign prod_r  = prod + (w_neg ? 54'h0FFFF : 54'd0);
  assign off_raw = prod_r[53:16];
  assign off_c   = (off_raw > 38'(OFF_MAX)) ? OFF_MAX : off_raw[22:0];

  assign nx     = ax_q ? no_q : na_q;
  assign ny     = ax_q ? na_q : no_q;
  assign chk_a  = fwd_a_q ? na_q : na_q - NW'(256);
  assign chkx   = ax_q ? no_q : chk_a;
  assign chky   = ax_q ? chk_a : no_q;
  assign scr_xl = {scr_w_q, 8'd0};
  assign scr_yl = {scr_h_q, 8'd0};
  assign mlim_x = {mw, TQ'(0)};
  assign mlim_y = {mh, TQ'(0)};
  assign onscr  = !nx[NW-1] && (nx[NW-2:0] < (NW-1)'(scr_xl)) &&
                  !ny[NW-1] && (ny[NW-2:0] < (NW-1)'(scr_yl));
  assign inmap  = !chkx[NW-1] && (chkx[NW-2:0] < (NW-1)'(mlim_x)) &&
                  !chky[NW-1] && (chky[NW-2:0] < (NW-1)'(mlim_y));
  assign rd_addr = CELL_AW'(chky[TQ+ROW_BITS-1:TQ] * mw) +
                   CELL_AW'(chkx[TQ+COL_BITS-1:TQ]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      ax_q        <= w_ax;
      fwd_a_q     <= w_fwd_a;
      fwd_o_q     <= w_fwd_o;
      slope_neg_q <= odd;
      slope_mag_q <= w_mag;
      dmag_q      <= w_fwd_a ? (TQ+1)'(1 << TQ) - (TQ+1)'(w_pa[TQ-1:0])
                             : (TQ+1)'(w_pa[TQ-1:0]);
      na_q        <= NW'({w_pa[19:TQ], TQ'(0)}) + (w_fwd_a ? NW'(1 << TQ) : NW'(0));
      stepo_q     <= (w_step_raw > (SW-2)'(OFF_MAX)) ? OFF_MAX : w_step_raw[22:0];
    end
    if (cmd_i.walk_mul) begin
      pp_lo_q <= dmag_q * slope_mag_q[19:0];
      pp_hi_q <= dmag_q * slope_mag_q[SW-1:20];
    end
    if (cmd_i.walk_start) begin
      no_q <= w_neg ? NW'(po) - NW'(off_c) : NW'(po) + NW'(off_c);
    end
    if (cmd_i.walk_eval && !rd_q) begin
      na_q <= fwd_a_q ? na_q + NW'(1 << TQ) : na_q - NW'(1 << TQ);
      no_q <= fwd_o_q ? no_q + NW'(stepo_q) : no_q - NW'(stepo_q);
    end
    if (cmd_i.walk_eval && rd_q) begin
      hpx_q[ax_q] <= nx[19:0];
      hpy_q[ax_q] <= ny[19:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hok_q <= 1'b0;
      vok_q <= 1'b0;
    end else if (cmd_i.load) begin
      hok_q <= 1'b0;
      vok_q <= 1'b0;
    end else if (cmd_i.walk_eval && rd_q) begin
      if (ax_q) hok_q <= 1'b1;
      else vok_q <= 1'b1;
    end
  end

  // Squared distances; entry 0 is the vertical-line hit.
  assign sq_a    = cnt_q[0] ? hpy_q[cnt_q[1]] : hpx_q[cnt_q[1]];
  assign sq_b    = cnt_q[0] ? item_q.player_y : item_q.player_x;
  assign sq_diff = {1'b0, sq_a} - {1'b0, sq_b};
  assign sq_abs  = sq_diff[20] ? 20'(-sq_diff) : sq_diff[19:0];
  assign sq_p    = sq_abs * sq_abs;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_init) begin
      dv_q <= '0;
      dh_q <= '0;
    end else if (cmd_i.sq_step) begin
      if (!cnt_q[1]) dv_q <= dv_q + 41'(sq_p);
      else dh_q <= dh_q + 41'(sq_p);
    end
  end

  // Bit-serial square root; the root of a 41-bit value stays below DIST_MAX.
  assign sq_t = res_q + {1'b0, bit_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel) begin
      use_v_q <= vok_q && (!hok_q || (dv_q <= dh_q));
      any_q   <= vok_q || hok_q;
      v_q     <= (vok_q && (!hok_q || (dv_q <= dh_q))) ? dv_q : dh_q;
      res_q   <= '0;
      bit_q   <= 41'(64'd1 << 40);
    end else if (cmd_i.sqrt_step) begin
      if ({1'b0, v_q} >= sq_t) begin
        v_q   <= 41'({1'b0, v_q} - sq_t);
        res_q <= (res_q >> 1) + {1'b0, bit_q};
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_strobe_q <= 1'b0;
    else res_strobe_q <= cmd_i.emit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_oq.ray_number_out <= item_q.ray_number;
      res_oq.hit            <= any_q;
      if (any_q) begin
        res_oq.end_x    <= use_v_q ? hpx_q[0] : hpx_q[1];
        res_oq.end_y    <= use_v_q ? hpy_q[0] : hpy_q[1];
        res_oq.distance <= res_q[20:0];
        res_oq.vert_hit <= use_v_q;
      end else begin
        res_oq.end_x    <= '0;
        res_oq.end_y    <= '0;
        res_oq.distance <= DIST_MAX;
        res_oq.vert_hit <= 1'b0;
      end
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_oq;

  assign sts_o.clr_done  = (clr_cnt_q == CELL_AW'(CELLS - 1));
  assign sts_o.is_cast   = in_i.func;
  assign sts_o.cnt_last  = (cnt_q == lim_q);
  assign sts_o.walk_skip = (r_ang == 10'd0) && (w_ax ? !odd : odd);
  assign sts_o.walk_stop = !onscr || !inmap;
  assign sts_o.walk_hit  = rd_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_q |=> !res_strobe_q)
    else $error("result beat lasted more than one cycle");

  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_q && !res_oq.hit |-> res_oq.distance == DIST_MAX && !res_oq.vert_hit)
    else $error("miss beat carries hit fields");

  a_vert_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_q && res_oq.vert_hit |-> vok_q)
    else $error("vertical result without a vertical-line hit");

  a_walk_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_init |-> $past(cmd_i.div_store) || $past(cmd_i.walk_init) ||
                        $past(cmd_i.walk_addr) || $past(cmd_i.walk_eval))
    else $error("walk started out of sequence");

endmodule

/* rtl/core/grid_ray_wall_caster_top.sv */
// A map write gives no result; a cast's result beat follows the 30-step
// rotation, two 47-step divisions, the two grid walks, four squaring steps
// and a 21-step root. A walk along an axis may be skipped; otherwise it
// examines one grid crossing after another until it stops or hits a wall.
// One item is in work at a time. After reset the map is cleared with busy high.
// ----------------------------------------------------------------------------
// grid_ray_wall_caster_top
// Tile wall map and single-ray grid caster, controller plus datapath.
// ----------------------------------------------------------------------------
module grid_ray_wall_caster_top import grcast_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_t         in_i,
  output logic        res_strobe_o,
  output out_t        res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  grcast_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  grcast_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

/* sim/tb_grid_ray_wall_caster_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_ray_wall_caster_top
// Self-checking bench for the grid ray wall caster. Map writes and ray casts
// are sent in a directed test, then in random bursts; a behavioural copy of the
// caster predicts each result beat, which is compared whole as it leaves the block.
// ----------------------------------------------------------------------------
module tb_grid_ray_wall_caster_top;
  import grcast_pkg::*;

  localparam longint TILE_Q8 = longint'(TILE_PIXELS) * 256;
  localparam int IDLE_LIMIT = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_t         in_i;
  logic        res_strobe_o;
  out_t        res_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_index_i;
  logic [11:0] cfg_data_i;

  grid_ray_wall_caster_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .res_strobe_o(res_strobe_o), .res_o(res_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  bit          wall_cells [CELLS];
  logic [11:0] scr_w = 12'd640;
  logic [11:0] scr_h = 12'd480;
  logic [5:0]  cols_in_use = 6'd32;
  logic [5:0]  rows_in_use = 6'd32;
  out_t        expected_rays [$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit trace_grid(input int axis, input longint px, input longint py,
                                    input longint slope, input bit fwd_a, input bit fwd_o,
                                    output longint hx, output longint hy);
    longint n [2];
    longint chk [2];
    longint scr [2];
    longint mlim [2];
    longint pos [2];
    longint d, step_a, step_o, mag, mw, mh, cell_no;
    int other;
    other = 1 - axis;
    pos[0] = px;
    pos[1] = py;
    mw = (cols_in_use > MAP_MAX_COLUMNS) ? MAP_MAX_COLUMNS : cols_in_use;
    mh = (rows_in_use > MAP_MAX_ROWS) ? MAP_MAX_ROWS : rows_in_use;
    scr[0] = longint'(scr_w) * 256;
    scr[1] = longint'(scr_h) * 256;
    mlim[0] = mw * TILE_Q8;
    mlim[1] = mh * TILE_Q8;
    n[axis] = (pos[axis] / TILE_Q8) * TILE_Q8 + (fwd_a ? TILE_Q8 : 0);
    d = n[axis] - pos[axis];
    n[other] = pos[other] + ((d * slope) >>> 16);
    step_a = fwd_a ? TILE_Q8 : -TILE_Q8;
    mag = (TILE_Q8 * (slope < 0 ? -slope : slope)) >>> 16;
    step_o = fwd_o ? mag : -mag;
    hx = 0;
    hy = 0;
    while (n[0] >= 0 && n[0] < scr[0] && n[1] >= 0 && n[1] < scr[1]) begin
      chk[0] = n[0];
      chk[1] = n[1];
      if (!fwd_a) chk[axis] -= 256;
      if (chk[0] < 0 || chk[0] >= mlim[0] || chk[1] < 0 || chk[1] >= mlim[1]) return 0;
      cell_no = (chk[1] / TILE_Q8) * mw + chk[0] / TILE_Q8;
      if (cell_no < CELLS && wall_cells[cell_no]) begin
        hx = n[0];
        hy = n[1];
        return 1;
      end
      n[0] += (axis == 0) ? step_a : step_o;
      n[1] += (axis == 1) ? step_a : step_o;
    end
    return 0;
  endfunction

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic out_t cast_ray_model(input in_t it);
    out_t o;
    longint px, py, x, y, z, xs, ys, c, s, tanv, cotv, hx, hy, vx, vy, ex, ey;
    longint unsigned dh, dv, dsq, root_v;
    logic [11:0] a;
    logic [9:0] r;
    bit odd, down, right, hok, vok, use_v;
    px = it.player_x;
    py = it.player_y;
    a = it.heading;
    r = a[9:0];
    odd = a[10];
    down = a > 0 && a < 12'd2048;
    right = a < 12'd1024 || a > 12'd3072;
    x = 64'sd1 << 29;
    y = 0;
    z = longint'(r) << 20;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_turn(i[4:0]));
      end else begin
        x += ys; y -= xs; z += longint'(atan_turn(i[4:0]));
      end
    end
    c = x > 0 ? x : 1;
    s = y > 0 ? y : 1;
    if (!odd) begin
      tanv = (s * 65536) / c;
      cotv = (c * 65536) / s;
    end else begin
      tanv = -((c * 65536) / s);
      cotv = -((s * 65536) / c);
    end
    hok = !(r == 0 && !odd) && trace_grid(1, px, py, cotv, down, right, hx, hy);
    vok = !(r == 0 && odd) && trace_grid(0, px, py, tanv, right, down, vx, vy);
    o = '0;
    o.ray_number_out = it.ray_number;
    o.distance = DIST_MAX;
    if (!hok && !vok) return o;
    dh = (hx - px) * (hx - px) + (hy - py) * (hy - py);
    dv = (vx - px) * (vx - px) + (vy - py) * (vy - py);
    use_v = vok && (!hok || dv <= dh);
    ex = use_v ? vx : hx;
    ey = use_v ? vy : hy;
    dsq = use_v ? dv : dh;
    root_v = int_root(dsq);
    o.hit = 1'b1;
    o.end_x = ex[19:0];
    o.end_y = ey[19:0];
    o.distance = (root_v > DIST_MAX) ? DIST_MAX : root_v[20:0];
    o.vert_hit = use_v;
    return o;
  endfunction

  // Leaves start high after the beat; the caller lowers it for a gap.
  task automatic send_item(input in_t it);
    start <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (busy);
    if (it.func) expected_rays.push_back(cast_ray_model(it));
    else wall_cells[it.cell_index] = it.cell_is_wall;
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic write_cell(input int idx, input bit wall);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.func = 1'b0;
    it.cell_index = idx[9:0];
    it.cell_is_wall = wall;
    send_item(it);
  endtask

  task automatic cast_ray(input int px, input int py, input int ang, input int num);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.func = 1'b1;
    it.player_x = px[19:0];
    it.player_y = py[19:0];
    it.heading = ang[11:0];
    it.ray_number = num[9:0];
    send_item(it);
  endtask

  // Called with start already low.
  task automatic drain_and_settle();
    while (expected_rays.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  // Leaves valid high after the beat; the caller lowers it.
  task automatic set_register(input cfg_idx_e idx, input logic [11:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SCREEN_WIDTH:  scr_w = value;
      CFG_SCREEN_HEIGHT: scr_h = value;
      CFG_MAP_WIDTH:     cols_in_use = value[5:0];
      CFG_MAP_HEIGHT:    rows_in_use = value[5:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_geometry(input int w, input int h, input int mc, input int mr);
    drain_and_settle();
    set_register(CFG_SCREEN_WIDTH, w[11:0]);
    set_register(CFG_SCREEN_HEIGHT, h[11:0]);
    set_register(CFG_MAP_WIDTH, mc[11:0]);
    set_register(CFG_MAP_HEIGHT, mr[11:0]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed_rays();
    write_cell(0, 1'b1);
    write_cell(1023, 1'b1);
    write_cell(5 * 32 + 3, 1'b1);
    write_cell(3 * 32 + 7, 1'b1);
    write_cell(2 * 32 + 2, 1'b1);
    write_cell(1023, 1'b0);
    cast_ray(160 * 256, 160 * 256, 0, 0);
    cast_ray(160 * 256, 160 * 256, 1024, 1023);
    cast_ray(160 * 256, 160 * 256, 2048, 1);
    cast_ray(160 * 256, 160 * 256, 3072, 2);
    cast_ray(200 * 256, 350 * 256, 512, 3);
    cast_ray(250 * 256, 250 * 256, 2560, 4);
    cast_ray(250 * 256, 250 * 256, 4095, 5);
    cast_ray(0, 0, 1, 6);
    cast_ray(20'hFFFFF, 20'hFFFFF, 2600, 7);
    cast_ray(128 * 256, 128 * 256, 2560, 8);
    cast_ray(64 * 256, 64 * 256, 2560, 9);
    cast_ray(639 * 256 + 255, 479 * 256 + 255, 2300, 10);
    pause_sender(1);
  endtask

  task automatic random_phase(input int casts, input int writes);
    int sent, burst, cw, ch, mw, mh;
    mw = (cols_in_use == 0) ? 1 : ((cols_in_use > 32) ? 32 : cols_in_use);
    mh = (rows_in_use == 0) ? 1 : ((rows_in_use > 32) ? 32 : rows_in_use);
    cw = (scr_w == 0) ? 1 : scr_w;
    ch = (scr_h == 0) ? 1 : scr_h;
    sent = 0;
    while (sent < casts + writes) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      repeat (burst) begin
        if (sent < writes) begin
          if ($urandom_range(0, 9) == 0) write_cell($urandom_range(0, 1023), $urandom);
          else write_cell($urandom_range(0, mh - 1) * mw + $urandom_range(0, mw - 1),
                          $urandom_range(0, 3) != 0);
        end else if ($urandom_range(0, 9) == 0) begin
          cast_ray($urandom, $urandom, $urandom, $urandom);
        end else begin
          cast_ray($urandom_range(0, cw * 256 - 1), $urandom_range(0, ch * 256 - 1),
                   ($urandom_range(0, 7) == 0) ? 1024 * $urandom_range(0, 3) : $urandom,
                   $urandom);
        end
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    pause_sender(0);
  endtask

  task automatic test_random_settings();
    random_phase(130, 40);
    set_geometry(4095, 4095, 63, 63);
    random_phase(110, 40);
    set_geometry(1, 1, 1, 1);
    random_phase(20, 5);
    set_geometry(2048, 2048, 0, 17);
    random_phase(20, 5);
    set_geometry(0, 300, 32, 32);
    random_phase(15, 0);
    set_geometry(1500, 900, 24, 14);
    random_phase(130, 40);
    set_geometry(640, 480, 32, 32);
    random_phase(60, 20);
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && res_strobe_o) begin
      if (expected_rays.size() == 0) begin
        $display("%0t: unexpected result beat, actual %p", $time, res_o);
        mismatches++;
      end else begin
        want = expected_rays.pop_front();
        if (res_o !== want) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, want, res_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || res_strobe_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SCREEN_WIDTH;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_rays();
    test_random_settings();
    drain_and_settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
